// ===== rtl/cmi_pkg.sv =====
package cmi_pkg;

  localparam int MUL_AW = 40;
  localparam int MUL_BW = 27;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 26;
  localparam int SQRT_W = 52;
  localparam int CFG_IW = 8;

  localparam logic [15:0] ZOOM_MIN = 16'd819;
  localparam logic [15:0] ZOOM_MAX = 16'd32768;
  localparam logic [15:0] ZOOM_ONE = 16'd8192;
  localparam logic signed [16:0] SNAP_GAP = 17'sd8;
  localparam logic signed [15:0] STICK_ONE = 16'sd16384;
  localparam logic [51:0] STICK_DEAD = 52'd26844;
  localparam logic [51:0] STICK_NORM = 52'd268435456;
  localparam logic [51:0] VEL_STOP = 52'd16384;
  localparam logic [31:0] FRIC_ONE = 32'd16777216;

  localparam logic [15:0] ZOOM_RATE_RST = 16'd2560;
  localparam logic [23:0] ACCEL_RATE_RST = 24'd512000;
  localparam logic [23:0] SPEED_LIMIT_RST = 24'd204800;
  localparam logic [15:0] FRICTION_RATE_RST = 16'd1280;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ZOOM_RATE = 8'd0,
    CFG_ACCEL_RATE = 8'd1,
    CFG_SPEED_LIMIT = 8'd2,
    CFG_FRICTION_RATE = 8'd3
  } cmi_cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ZK, ST_ZG, ST_ZA, ST_SX, ST_SY, ST_SQ,
    ST_MAG_GO, ST_MAG_WAIT, ST_DX_GO, ST_DX_WAIT, ST_DY_GO, ST_DY_WAIT,
    ST_AK, ST_AX, ST_AY, ST_AV, ST_VX2, ST_VY2, ST_VS, ST_VCMP,
    ST_VSQ_GO, ST_VSQ_WAIT, ST_NX, ST_NX_GO, ST_NX_WAIT,
    ST_NY, ST_NY_GO, ST_NY_WAIT, ST_VCLAMP,
    ST_FK, ST_FC, ST_FX, ST_FY, ST_FW,
    ST_PK, ST_PX, ST_PY, ST_PW, ST_OUT
  } cmi_state_t;

endpackage

// ===== rtl/camera_motion_integrator.sv =====
// channel | dir | signals                                 | request
// s       | in  | s_tvalid s_tready s_tdata[127:0] s_tuser | one tick
// m       | out | m_tvalid m_tready m_tdata[127:0]         | one result
// cfg     | in  | cfg_valid cfg_ready cfg_index cfg_data    | one register write
// A tick runs its products through the shared 40x27 multiplier, one product a cycle.
// Stick normalizing adds a 26-step square root and two 49-step divides;
// speed limiting adds the same again.
// rst is synchronous; it restores register defaults and the camera state.
// s_tready is high only while idle; a result waits in the output register
// while the next request is accepted, and a tick holds at its end until m is free.
module camera_motion_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // time_step[15:0] move_x[31:16] move_y[47:32] goal_zoom[63:48] new_x[95:64] new_y[127:96]
  input  logic [127:0] s_tdata,
  // snap_zoom[0] teleport[1]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x[31:0] pos_y[63:32] zoom_now[79:64] vel_x[103:80] vel_y[127:104]
  output logic [127:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [cmi_pkg::CFG_IW-1:0] cfg_index,
  input  logic [23:0]  cfg_data
);

  cmi_pkg::cmi_state_t state, state_next;

  logic [15:0] zoom_rate, friction_rate;
  logic [23:0] accel_rate, speed_limit;

  logic [15:0] dt, goal, zoom;
  logic signed [15:0] mx, my;
  logic signed [31:0] px, py;
  logic signed [23:0] vx, vy;
  logic signed [25:0] vwx, vwy;
  logic [cmi_pkg::MUL_PW-1:0] prod;
  logic [cmi_pkg::MUL_AW-1:0] mul_a, ak;
  logic [cmi_pkg::MUL_BW-1:0] mul_b;
  logic [51:0] acc, sq;
  logic [25:0] den;
  logic [30:0] zd;
  logic [24:0] sc;
  logic        active;

  logic s_fire, out_load;

  logic        sqrt_start, sqrt_done, sqrt_rem_nz;
  logic [25:0] sqrt_root;
  logic        div_start, div_done;
  logic [cmi_pkg::DIV_NW-1:0] div_num, div_quo;

  logic signed [15:0] in_mx, in_my, cl_mx, cl_my;
  logic [15:0] in_goal, cl_goal;
  logic [15:0] mx_neg, my_neg;
  logic [14:0] mx_mag, my_mag;
  logic [25:0] vwx_neg, vwy_neg;
  logic [24:0] vwx_mag, vwy_mag;
  logic [23:0] vx_neg, vy_neg, vx_mag, vy_mag;
  logic [16:0] gap, gap_neg;
  logic [15:0] gap_mag;
  logic signed [24:0] zsum;
  logic [15:0] zc;
  logic [16:0] gap2;
  logic [51:0] sum_c;
  logic signed [25:0] vx_ext, vy_ext, acc_x, acc_y, lim_x, lim_y;
  logic [23:0] fr_x, fr_y;
  logic signed [32:0] pos_x_sum, pos_y_sum;
  logic [31:0] pos_x_sat, pos_y_sat;
  logic [23:0] vwx_sat, vwy_sat;

  assign cfg_ready = 1'b1;
  assign s_fire = s_tvalid && s_tready;

  assign in_mx = s_tdata[31:16];
  assign in_my = s_tdata[47:32];
  assign in_goal = s_tdata[63:48];
  assign cl_mx = (in_mx < -cmi_pkg::STICK_ONE) ? -cmi_pkg::STICK_ONE :
                 (in_mx > cmi_pkg::STICK_ONE) ? cmi_pkg::STICK_ONE : in_mx;
  assign cl_my = (in_my < -cmi_pkg::STICK_ONE) ? -cmi_pkg::STICK_ONE :
                 (in_my > cmi_pkg::STICK_ONE) ? cmi_pkg::STICK_ONE : in_my;
  assign cl_goal = (in_goal < cmi_pkg::ZOOM_MIN) ? cmi_pkg::ZOOM_MIN :
                   (in_goal > cmi_pkg::ZOOM_MAX) ? cmi_pkg::ZOOM_MAX : in_goal;

  assign mx_neg = 16'(0) - mx;
  assign my_neg = 16'(0) - my;
  assign mx_mag = mx[15] ? mx_neg[14:0] : mx[14:0];
  assign my_mag = my[15] ? my_neg[14:0] : my[14:0];
  assign vwx_neg = 26'(0) - vwx;
  assign vwy_neg = 26'(0) - vwy;
  assign vwx_mag = vwx[25] ? vwx_neg[24:0] : vwx[24:0];
  assign vwy_mag = vwy[25] ? vwy_neg[24:0] : vwy[24:0];
  assign vx_neg = 24'(0) - vx;
  assign vy_neg = 24'(0) - vy;
  assign vx_mag = vx[23] ? vx_neg : vx;
  assign vy_mag = vy[23] ? vy_neg : vy;

  assign gap = {1'b0, goal} - {1'b0, zoom};
  assign gap_neg = 17'(0) - gap;
  assign gap_mag = gap[16] ? gap_neg[15:0] : gap[15:0];
  assign zsum = gap[16] ? $signed({9'b0, zoom}) - $signed({2'b0, prod[46:24]})
                        : $signed({9'b0, zoom}) + $signed({2'b0, prod[46:24]});
  assign zc = (zsum < $signed({9'b0, cmi_pkg::ZOOM_MIN})) ? cmi_pkg::ZOOM_MIN :
              (zsum > $signed({9'b0, cmi_pkg::ZOOM_MAX})) ? cmi_pkg::ZOOM_MAX : zsum[15:0];
  assign gap2 = {1'b0, goal} - {1'b0, zc};

  assign sum_c = acc + prod[51:0];

  assign vx_ext = {{2{vx[23]}}, vx};
  assign vy_ext = {{2{vy[23]}}, vy};
  assign acc_x = mx[15] ? vx_ext - $signed({1'b0, prod[54:30]})
                        : vx_ext + $signed({1'b0, prod[54:30]});
  assign acc_y = my[15] ? vy_ext - $signed({1'b0, prod[54:30]})
                        : vy_ext + $signed({1'b0, prod[54:30]});
  assign lim_x = vwx[25] ? 26'(0) - div_quo[25:0] : div_quo[25:0];
  assign lim_y = vwy[25] ? 26'(0) - div_quo[25:0] : div_quo[25:0];
  assign fr_x = vx[23] ? 24'(0) - prod[47:24] : prod[47:24];
  assign fr_y = vy[23] ? 24'(0) - prod[47:24] : prod[47:24];

  assign vwx_sat = (vwx > 26'sd8388607) ? 24'h7FFFFF :
                   (vwx < -26'sd8388608) ? 24'h800000 : vwx[23:0];
  assign vwy_sat = (vwy > 26'sd8388607) ? 24'h7FFFFF :
                   (vwy < -26'sd8388608) ? 24'h800000 : vwy[23:0];

  assign pos_x_sum = vx[23] ? {px[31], px} - $signed({7'b0, prod[54:29]})
                            : {px[31], px} + $signed({7'b0, prod[54:29]});
  assign pos_y_sum = vy[23] ? {py[31], py} - $signed({7'b0, prod[54:29]})
                            : {py[31], py} + $signed({7'b0, prod[54:29]});
  assign pos_x_sat = (pos_x_sum[32] != pos_x_sum[31]) ?
                     (pos_x_sum[32] ? 32'h80000000 : 32'h7FFFFFFF) : pos_x_sum[31:0];
  assign pos_y_sat = (pos_y_sum[32] != pos_y_sum[31]) ?
                     (pos_y_sum[32] ? 32'h80000000 : 32'h7FFFFFFF) : pos_y_sum[31:0];

  cmi_sqrt #(.W(cmi_pkg::SQRT_W)) u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sqrt_start),
    .rad    (sq),
    .done   (sqrt_done),
    .root   (sqrt_root),
    .rem_nz (sqrt_rem_nz)
  );

  cmi_div #(.NW(cmi_pkg::DIV_NW), .DW(cmi_pkg::DIV_DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      cmi_pkg::ST_IDLE:     if (s_fire) state_next = cmi_pkg::ST_ZK;
      cmi_pkg::ST_ZK:       state_next = cmi_pkg::ST_ZG;
      cmi_pkg::ST_ZG:       state_next = cmi_pkg::ST_ZA;
      cmi_pkg::ST_ZA:       state_next = cmi_pkg::ST_SX;
      cmi_pkg::ST_SX:       state_next = cmi_pkg::ST_SY;
      cmi_pkg::ST_SY:       state_next = cmi_pkg::ST_SQ;
      cmi_pkg::ST_SQ: begin
        if (sum_c < cmi_pkg::STICK_DEAD) state_next = cmi_pkg::ST_VX2;
        else if (sum_c > cmi_pkg::STICK_NORM) state_next = cmi_pkg::ST_MAG_GO;
        else state_next = cmi_pkg::ST_AK;
      end
      cmi_pkg::ST_MAG_GO:   state_next = cmi_pkg::ST_MAG_WAIT;
      cmi_pkg::ST_MAG_WAIT: if (sqrt_done) state_next = cmi_pkg::ST_DX_GO;
      cmi_pkg::ST_DX_GO:    state_next = cmi_pkg::ST_DX_WAIT;
      cmi_pkg::ST_DX_WAIT:  if (div_done) state_next = cmi_pkg::ST_DY_GO;
      cmi_pkg::ST_DY_GO:    state_next = cmi_pkg::ST_DY_WAIT;
      cmi_pkg::ST_DY_WAIT:  if (div_done) state_next = cmi_pkg::ST_AK;
      cmi_pkg::ST_AK:       state_next = cmi_pkg::ST_AX;
      cmi_pkg::ST_AX:       state_next = cmi_pkg::ST_AY;
      cmi_pkg::ST_AY:       state_next = cmi_pkg::ST_AV;
      cmi_pkg::ST_AV:       state_next = cmi_pkg::ST_VX2;
      cmi_pkg::ST_VX2:      state_next = cmi_pkg::ST_VY2;
      cmi_pkg::ST_VY2:      state_next = cmi_pkg::ST_VS;
      cmi_pkg::ST_VS:       state_next = cmi_pkg::ST_VCMP;
      cmi_pkg::ST_VCMP: begin
        if (active) begin
          state_next = (sq > prod[51:0]) ? cmi_pkg::ST_VSQ_GO : cmi_pkg::ST_VCLAMP;
        end else begin
          state_next = (sq <= cmi_pkg::VEL_STOP) ? cmi_pkg::ST_PK : cmi_pkg::ST_FK;
        end
      end
      cmi_pkg::ST_VSQ_GO:   state_next = cmi_pkg::ST_VSQ_WAIT;
      cmi_pkg::ST_VSQ_WAIT: if (sqrt_done) state_next = cmi_pkg::ST_NX;
      cmi_pkg::ST_NX:       state_next = cmi_pkg::ST_NX_GO;
      cmi_pkg::ST_NX_GO:    state_next = cmi_pkg::ST_NX_WAIT;
      cmi_pkg::ST_NX_WAIT:  if (div_done) state_next = cmi_pkg::ST_NY;
      cmi_pkg::ST_NY:       state_next = cmi_pkg::ST_NY_GO;
      cmi_pkg::ST_NY_GO:    state_next = cmi_pkg::ST_NY_WAIT;
      cmi_pkg::ST_NY_WAIT:  if (div_done) state_next = cmi_pkg::ST_VCLAMP;
      cmi_pkg::ST_VCLAMP:   state_next = cmi_pkg::ST_PK;
      cmi_pkg::ST_FK:       state_next = cmi_pkg::ST_FC;
      cmi_pkg::ST_FC: begin
        state_next = (prod[31:0] > cmi_pkg::FRIC_ONE) ? cmi_pkg::ST_PK : cmi_pkg::ST_FX;
      end
      cmi_pkg::ST_FX:       state_next = cmi_pkg::ST_FY;
      cmi_pkg::ST_FY:       state_next = cmi_pkg::ST_FW;
      cmi_pkg::ST_FW:       state_next = cmi_pkg::ST_PK;
      cmi_pkg::ST_PK:       state_next = cmi_pkg::ST_PX;
      cmi_pkg::ST_PX:       state_next = cmi_pkg::ST_PY;
      cmi_pkg::ST_PY:       state_next = cmi_pkg::ST_PW;
      cmi_pkg::ST_PW:       state_next = cmi_pkg::ST_OUT;
      cmi_pkg::ST_OUT:      if (out_load) state_next = cmi_pkg::ST_IDLE;
      default:              state_next = cmi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    out_load   = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      cmi_pkg::ST_IDLE:  s_tready = 1'b1;
      cmi_pkg::ST_ZK: begin
        mul_a = 40'(dt);
        mul_b = 27'(zoom_rate);
      end
      cmi_pkg::ST_ZG: begin
        mul_a = 40'(prod[31:0]);
        mul_b = 27'(gap_mag);
      end
      cmi_pkg::ST_SX: begin
        mul_a = 40'(mx_mag);
        mul_b = 27'(mx_mag);
      end
      cmi_pkg::ST_SY: begin
        mul_a = 40'(my_mag);
        mul_b = 27'(my_mag);
      end
      cmi_pkg::ST_MAG_GO: sqrt_start = 1'b1;
      cmi_pkg::ST_DX_GO: begin
        div_start = 1'b1;
        div_num   = cmi_pkg::DIV_NW'({mx_mag, 14'b0});
      end
      cmi_pkg::ST_DY_GO: begin
        div_start = 1'b1;
        div_num   = cmi_pkg::DIV_NW'({my_mag, 14'b0});
      end
      cmi_pkg::ST_AK: begin
        mul_a = 40'(accel_rate);
        mul_b = 27'(dt);
      end
      cmi_pkg::ST_AX: begin
        mul_a = prod[39:0];
        mul_b = 27'(mx_mag);
      end
      cmi_pkg::ST_AY: begin
        mul_a = ak;
        mul_b = 27'(my_mag);
      end
      cmi_pkg::ST_VX2: begin
        mul_a = 40'(vwx_mag);
        mul_b = 27'(vwx_mag);
      end
      cmi_pkg::ST_VY2: begin
        mul_a = 40'(vwy_mag);
        mul_b = 27'(vwy_mag);
      end
      cmi_pkg::ST_VS: begin
        mul_a = 40'(speed_limit);
        mul_b = 27'(speed_limit);
      end
      cmi_pkg::ST_VSQ_GO: sqrt_start = 1'b1;
      cmi_pkg::ST_NX: begin
        mul_a = 40'(vwx_mag);
        mul_b = 27'(speed_limit);
      end
      cmi_pkg::ST_NX_GO, cmi_pkg::ST_NY_GO: begin
        div_start = 1'b1;
        div_num   = prod[cmi_pkg::DIV_NW-1:0];
      end
      cmi_pkg::ST_NY: begin
        mul_a = 40'(vwy_mag);
        mul_b = 27'(speed_limit);
      end
      cmi_pkg::ST_FK: begin
        mul_a = 40'(friction_rate);
        mul_b = 27'(dt);
      end
      cmi_pkg::ST_FX: begin
        mul_a = 40'(vx_mag);
        mul_b = 27'(sc);
      end
      cmi_pkg::ST_FY: begin
        mul_a = 40'(vy_mag);
        mul_b = 27'(sc);
      end
      cmi_pkg::ST_PK: begin
        mul_a = 40'(zoom);
        mul_b = 27'(dt);
      end
      cmi_pkg::ST_PX: begin
        mul_a = 40'(prod[30:0]);
        mul_b = 27'(vx_mag);
      end
      cmi_pkg::ST_PY: begin
        mul_a = 40'(zd);
        mul_b = 27'(vy_mag);
      end
      cmi_pkg::ST_OUT: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {27'b0, mul_a} * {40'b0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_rate     <= cmi_pkg::ZOOM_RATE_RST;
      accel_rate    <= cmi_pkg::ACCEL_RATE_RST;
      speed_limit   <= cmi_pkg::SPEED_LIMIT_RST;
      friction_rate <= cmi_pkg::FRICTION_RATE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cmi_pkg::CFG_ZOOM_RATE:     zoom_rate     <= cfg_data[15:0];
        cmi_pkg::CFG_ACCEL_RATE:    accel_rate    <= cfg_data;
        cmi_pkg::CFG_SPEED_LIMIT:   speed_limit   <= cfg_data;
        cmi_pkg::CFG_FRICTION_RATE: friction_rate <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cmi_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      px       <= '0;
      py       <= '0;
      vx       <= '0;
      vy       <= '0;
      zoom     <= cmi_pkg::ZOOM_ONE;
      goal     <= cmi_pkg::ZOOM_ONE;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {vy, vx, zoom, py, px};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        cmi_pkg::ST_IDLE: begin
          if (s_fire) begin
            dt   <= s_tdata[15:0];
            mx   <= cl_mx;
            my   <= cl_my;
            goal <= cl_goal;
            if (s_tuser[0]) zoom <= cl_goal;
            if (s_tuser[1]) begin
              px <= s_tdata[95:64];
              py <= s_tdata[127:96];
              vx <= '0;
              vy <= '0;
            end
          end
        end
        cmi_pkg::ST_ZA: begin
          if ($signed(gap2) <= cmi_pkg::SNAP_GAP && $signed(gap2) >= -cmi_pkg::SNAP_GAP) begin
            zoom <= goal;
          end else begin
            zoom <= zc;
          end
        end
        cmi_pkg::ST_SY: acc <= prod[51:0];
        cmi_pkg::ST_SQ: begin
          sq     <= sum_c;
          active <= sum_c >= cmi_pkg::STICK_DEAD;
          vwx    <= vx_ext;
          vwy    <= vy_ext;
        end
        cmi_pkg::ST_MAG_WAIT: if (sqrt_done) den <= sqrt_root;
        cmi_pkg::ST_DX_WAIT: if (div_done) mx <= mx[15] ? 16'(0) - div_quo[15:0] : div_quo[15:0];
        cmi_pkg::ST_DY_WAIT: if (div_done) my <= my[15] ? 16'(0) - div_quo[15:0] : div_quo[15:0];
        cmi_pkg::ST_AX: ak <= prod[39:0];
        cmi_pkg::ST_AY: vwx <= acc_x;
        cmi_pkg::ST_AV: vwy <= acc_y;
        cmi_pkg::ST_VY2: acc <= prod[51:0];
        cmi_pkg::ST_VS: sq <= sum_c;
        cmi_pkg::ST_VCMP: begin
          if (!active && sq <= cmi_pkg::VEL_STOP) begin
            vx <= '0;
            vy <= '0;
          end
        end
        cmi_pkg::ST_VSQ_WAIT: if (sqrt_done) den <= sqrt_root + 26'(sqrt_rem_nz);
        cmi_pkg::ST_NX_WAIT: if (div_done) vwx <= lim_x;
        cmi_pkg::ST_NY_WAIT: if (div_done) vwy <= lim_y;
        cmi_pkg::ST_VCLAMP: begin
          vx <= vwx_sat;
          vy <= vwy_sat;
        end
        cmi_pkg::ST_FC: begin
          if (prod[31:0] > cmi_pkg::FRIC_ONE) begin
            vx <= '0;
            vy <= '0;
          end
          sc <= 25'(cmi_pkg::FRIC_ONE) - prod[24:0];
        end
        cmi_pkg::ST_FY: vx <= fr_x;
        cmi_pkg::ST_FW: vy <= fr_y;
        cmi_pkg::ST_PX: zd <= prod[30:0];
        cmi_pkg::ST_PY: px <= pos_x_sat;
        cmi_pkg::ST_PW: py <= pos_y_sat;
        default: ;
      endcase
    end
  end

  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("request accepted while a tick is in flight");

  a_zoom_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[79:64] >= cmi_pkg::ZOOM_MIN && m_tdata[79:64] <= cmi_pkg::ZOOM_MAX))
    else $error("zoom out of range");

  a_sqrt_wait: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == cmi_pkg::ST_MAG_WAIT || state == cmi_pkg::ST_VSQ_WAIT))
    else $error("square root finished outside a wait state");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == cmi_pkg::ST_OUT && m_tvalid && !m_tready) |=> state == cmi_pkg::ST_OUT)
    else $error("result overwritten before it was taken");

endmodule

// ===== rtl/cmi_div.sv =====
module cmi_div #(
  parameter int NW = cmi_pkg::DIV_NW,
  parameter int DW = cmi_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [NW-1:0] q;
  logic [DW-1:0] d;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          ge;

  assign rem_sh = {rem[DW-1:0], q[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, d};
  assign ge     = !diff[DW+1];
  assign quo    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        q    <= num;
        d    <= den;
      end else if (busy) begin
        rem <= ge ? diff[DW:0] : rem_sh;
        q   <= {q[NW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/cmi_sqrt.sv =====
module cmi_sqrt #(
  parameter int W = cmi_pkg::SQRT_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   rad,
  output logic           done,
  output logic [W/2-1:0] root,
  output logic           rem_nz
);

  localparam int CW = $clog2(W / 2 + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  n;
  logic [W-1:0]  r;
  logic [W-1:0]  b;
  logic [W-1:0]  t;

  assign t      = r + b;
  assign root   = r[W/2-1:0];
  assign rem_nz = |n;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W / 2);
        n    <= rad;
        r    <= '0;
        b    <= W'(1) << (W - 2);
      end else if (busy) begin
        if (n >= t) begin
          n <= n - t;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b   <= b >> 2;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
